FILE: rtl/tdp_pkg.sv
package tdp_pkg;

    // Width of the candidate and echoed value fields on the channels
    localparam int unsigned FIELD_WIDTH = 32;

    // Constants of the 6k +/- 1 trial division scheme
    localparam int unsigned LAST_SMALL_PRIME = 3;
    localparam int unsigned FIRST_DIVISOR    = 5;
    localparam int unsigned PAIR_OFFSET      = 2;
    localparam int unsigned DIVISOR_STEP     = 6;

    // Control from the sequencer to the shared divider
    typedef struct packed {
        logic start;
    } div_ctl_t;

    // Status from the shared divider back to the sequencer
    typedef struct packed {
        logic done;
    } div_sts_t;

endpackage

FILE: rtl/tdp_in_if.sv
interface tdp_in_if import tdp_pkg::*;;

    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);

endinterface

FILE: rtl/tdp_out_if.sv
interface tdp_out_if import tdp_pkg::*;;

    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] tested_value;
    logic                   is_prime;

    modport source (output valid, output tested_value, output is_prime, input ready);
    modport sink   (input valid, input tested_value, input is_prime, output ready);

endinterface

FILE: rtl/tdp_divider.sv
// Restoring divider: one quotient bit per cycle.
module tdp_divider import tdp_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctl_t         ctl,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output div_sts_t         sts,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] dvs_reg;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] quo_next;

    // Shift in the next dividend bit and try to subtract the divisor
    always_comb
    begin
        trial    = {rem_reg, quo_reg[WIDTH-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = !diff[WIDTH];
        rem_next = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        quo_next = {quo_reg[WIDTH-2:0], fits};
    end

    // Count the steps and pulse done after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Load operands on start, then advance one bit per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign sts.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/trial_division_primality.sv
// Channel | Dir | Fields                          | Meaning
// in_ch   | in  | candidate[31:0]                 | value to test (low VALUE_WIDTH bits)
// out_ch  | out | tested_value[31:0], is_prime    | echoed value and prime flag
//
// One word at a time. Values 0..3 and even values go from TRIAGE straight to EMIT, which
// loads the output register. Others run one division by 3, then divisor pairs d, d+2
// (d = 5, 11, ...) while d <= value / d, each on the shared bit-serial divider of width
// min(VALUE_WIDTH, 32). in_ch.ready is high only while idle; a finished word waits in the
// output register, and the next word may be taken while it waits. Reset is async.
module trial_division_primality import tdp_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    tdp_in_if.sink    in_ch,
    tdp_out_if.source out_ch
);

    localparam int VW = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;

    typedef enum logic [2:0] {
        IDLE,
        TRIAGE,
        MOD3,
        MOD_LO,
        MOD_HI,
        EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [VW-1:0]          value_reg, value_next;
    logic [VW-1:0]          div_reg, div_next;
    logic                   prime_reg, prime_next;
    logic                   start_reg, start_next;
    logic [VW-1:0]          dvs_reg, dvs_next;
    logic                   out_valid_reg, out_valid_next;
    logic [FIELD_WIDTH-1:0] out_value_reg, out_value_next;
    logic                   out_prime_reg, out_prime_next;

    div_ctl_t               div_ctl;
    div_sts_t               div_sts;
    logic [VW-1:0]          div_quo;
    logic [VW-1:0]          div_rem;

    assign div_ctl.start = start_reg;

    tdp_divider #(
        .WIDTH (VW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (value_reg),
        .divisor   (dvs_reg),
        .sts       (div_sts),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sequence the trial divisions
    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        div_next       = div_reg;
        prime_next     = prime_reg;
        start_next     = 1'b0;
        dvs_next       = dvs_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_value_next = out_value_reg;
        out_prime_next = out_prime_reg;

        unique case (state_reg)
            IDLE:
            begin
                if (in_ch.valid)
                begin
                    value_next = in_ch.candidate[VW-1:0];
                    state_next = TRIAGE;
                end
            end
            TRIAGE:
            begin
                if (value_reg <= VW'(1))
                begin
                    prime_next = 1'b0;
                    state_next = EMIT;
                end
                else if (value_reg <= VW'(LAST_SMALL_PRIME))
                begin
                    prime_next = 1'b1;
                    state_next = EMIT;
                end
                else if (!value_reg[0])
                begin
                    prime_next = 1'b0;
                    state_next = EMIT;
                end
                else
                begin
                    start_next = 1'b1;
                    dvs_next   = VW'(LAST_SMALL_PRIME);
                    state_next = MOD3;
                end
            end
            MOD3:
            begin
                if (div_sts.done)
                begin
                    if (div_rem == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = EMIT;
                    end
                    else
                    begin
                        div_next   = VW'(FIRST_DIVISOR);
                        start_next = 1'b1;
                        dvs_next   = VW'(FIRST_DIVISOR);
                        state_next = MOD_LO;
                    end
                end
            end
            MOD_LO:
            begin
                // Stop once d exceeds value / d: no factor remains below sqrt
                if (div_sts.done)
                begin
                    if (div_reg > div_quo)
                    begin
                        prime_next = 1'b1;
                        state_next = EMIT;
                    end
                    else if (div_rem == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = EMIT;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        dvs_next   = div_reg + VW'(PAIR_OFFSET);
                        state_next = MOD_HI;
                    end
                end
            end
            MOD_HI:
            begin
                if (div_sts.done)
                begin
                    if (div_rem == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = EMIT;
                    end
                    else
                    begin
                        div_next   = div_reg + VW'(DIVISOR_STEP);
                        start_next = 1'b1;
                        dvs_next   = div_reg + VW'(DIVISOR_STEP);
                        state_next = MOD_LO;
                    end
                end
            end
            EMIT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = FIELD_WIDTH'(value_reg);
                    out_prime_next = prime_reg;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // Hold state, divider start and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Advance the datapath registers
    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        div_reg       <= div_next;
        prime_reg     <= prime_next;
        dvs_reg       <= dvs_next;
        out_value_reg <= out_value_next;
        out_prime_reg <= out_prime_next;
    end

    assign in_ch.ready         = (state_reg == IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.tested_value = out_value_reg;
    assign out_ch.is_prime     = out_prime_reg;

endmodule

FILE: rtl/tdp_checker.sv
module tdp_checker import tdp_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic [FIELD_WIDTH-1:0] candidate,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [FIELD_WIDTH-1:0] tested_value,
    input logic                   is_prime
);

    // A stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tested_value) && $stable(is_prime))
        else $error("output word changed while stalled");

    // Drop ready for the word's work after taking it
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word is in work");

    // Zero and one are never prime
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (tested_value == '0 || tested_value == FIELD_WIDTH'(1)) |-> !is_prime)
        else $error("zero or one reported prime");

    // Even values other than two are never prime
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tested_value[0] && tested_value != FIELD_WIDTH'(2) |-> !is_prime)
        else $error("even value reported prime");

    // A word taken from an idle, empty block cannot appear at the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid && (candidate != '0) |=> !out_valid)
        else $error("result appeared too early");

endmodule

bind trial_division_primality tdp_checker u_tdp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .candidate    (in_ch.candidate),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .tested_value (out_ch.tested_value),
    .is_prime     (out_ch.is_prime)
);
